FILE: rtl/fcp_pkg.sv
// ----------------------------------------------------------------------------
// fcp_pkg
// Shared types, constants and helpers for the frame change percentage block.
// ----------------------------------------------------------------------------
`default_nettype none

package fcp_pkg;

    localparam int CHAN_W   = 8;
    localparam int COUNT_W  = 24;
    localparam int SHARE_W  = 14;
    localparam int STEP_W   = $clog2(SHARE_W);

    localparam logic [COUNT_W-1:0] MAX_PIXELS = 24'd8388608;

    // gray = (dB*1868 + dG*9617 + dR*4899 + 8192) >> 14
    localparam int PROD_B_W = 19;
    localparam int PROD_G_W = 22;
    localparam int PROD_R_W = 21;
    localparam int GRAY_SUM_W = 22;
    localparam int GRAY_SHIFT = 14;
    localparam logic [10:0] COEF_B = 11'd1868;
    localparam logic [13:0] COEF_G = 14'd9617;
    localparam logic [12:0] COEF_R = 13'd4899;
    localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = 22'd8192;

    // share = floor(changed * 10000 / total), done as a restoring divide
    localparam logic [SHARE_W-1:0] SHARE_SCALE = 14'd10000;
    localparam int DIV_W = COUNT_W + SHARE_W - 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic               mask;
        logic               last;
        logic [COUNT_W-1:0] changed;
        logic [COUNT_W-1:0] total;
    } fcp_item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_FIN
    } back_state_t;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] r;
        r = (a > b) ? (a - b) : (b - a);
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        r = (v < MAX_PIXELS) ? (v + 1'b1) : MAX_PIXELS;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fcp_front.sv
// ----------------------------------------------------------------------------
// fcp_front
// Pixel intake: channel differences, gray weighting, threshold and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_front import fcp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [CHAN_W-1:0] cfg_wr_data,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire logic [CHAN_W-1:0] prev_blue,
    input  wire logic [CHAN_W-1:0] prev_green,
    input  wire logic [CHAN_W-1:0] prev_red,
    input  wire logic [CHAN_W-1:0] curr_blue,
    input  wire logic [CHAN_W-1:0] curr_green,
    input  wire logic [CHAN_W-1:0] curr_red,
    input  wire logic              last_pixel,
    input  wire logic              q_full,
    output      logic              q_push,
    output      fcp_item_t         q_item
);

    logic [CHAN_W-1:0]     thr_reg;
    logic                  s1_valid_reg, s1_valid_next;
    logic                  last_reg;
    logic [PROD_B_W-1:0]   prod_b_reg, prod_b_next;
    logic [PROD_G_W-1:0]   prod_g_reg, prod_g_next;
    logic [PROD_R_W-1:0]   prod_r_reg, prod_r_next;
    logic [COUNT_W-1:0]    pix_cnt_reg, pix_cnt_next;
    logic [COUNT_W-1:0]    chg_cnt_reg, chg_cnt_next;
    logic [GRAY_SUM_W-1:0] gray_sum;
    logic [CHAN_W-1:0]     gray;
    logic                  changed;
    logic [COUNT_W-1:0]    pix_inc;
    logic [COUNT_W-1:0]    chg_inc;
    logic                  take;

    assign in_ready = !s1_valid_reg || !q_full;
    assign take     = in_valid && in_ready;
    assign q_push   = s1_valid_reg && !q_full;

    assign prod_b_next = PROD_B_W'(abs_diff(prev_blue, curr_blue)) * PROD_B_W'(COEF_B);
    assign prod_g_next = PROD_G_W'(abs_diff(prev_green, curr_green)) * PROD_G_W'(COEF_G);
    assign prod_r_next = PROD_R_W'(abs_diff(prev_red, curr_red)) * PROD_R_W'(COEF_R);

    assign gray_sum = GRAY_SUM_W'(prod_b_reg) + GRAY_SUM_W'(prod_g_reg)
                    + GRAY_SUM_W'(prod_r_reg) + GRAY_ROUND;
    assign gray     = gray_sum[GRAY_SHIFT +: CHAN_W];
    assign changed  = gray > thr_reg;
    assign pix_inc  = sat_inc(pix_cnt_reg);
    assign chg_inc  = changed ? sat_inc(chg_cnt_reg) : chg_cnt_reg;

    always_comb
    begin
        q_item.mask    = changed;
        q_item.last    = last_reg;
        q_item.changed = chg_inc;
        q_item.total   = pix_inc;
        s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
        pix_cnt_next   = pix_cnt_reg;
        chg_cnt_next   = chg_cnt_reg;
        if (q_push)
        begin
            pix_cnt_next = last_reg ? '0 : pix_inc;
            chg_cnt_next = last_reg ? '0 : chg_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= 8'd32;
            s1_valid_reg <= 1'b0;
            pix_cnt_reg  <= '0;
            chg_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            s1_valid_reg <= s1_valid_next;
            pix_cnt_reg  <= pix_cnt_next;
            chg_cnt_reg  <= chg_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prod_b_reg <= prod_b_next;
            prod_g_reg <= prod_g_next;
            prod_r_reg <= prod_r_next;
            last_reg   <= last_pixel;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fcp_queue.sv
// ----------------------------------------------------------------------------
// fcp_queue
// Short register queue between the pixel front end and the result back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_queue import fcp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire fcp_item_t push_item,
    output      logic      full,
    input  wire logic      pop,
    output      logic      empty,
    output      fcp_item_t head
);

    fcp_item_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign full  = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fcp_back.sv
// ----------------------------------------------------------------------------
// fcp_back
// Result stage: passes pixel masks through and, at frame end, divides out
// the changed share one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_back import fcp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire fcp_item_t          q_head,
    output      logic               q_pop,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic               mask_bit,
    output      logic               frame_done,
    output      logic [COUNT_W-1:0] changed_pixels,
    output      logic [SHARE_W-1:0] changed_hundredths
);

    back_state_t        state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [SHARE_W-1:0] quot_reg, quot_next;
    logic [COUNT_W-1:0] cnt_hold_reg, cnt_hold_next;
    logic               mask_hold_reg, mask_hold_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_mask_reg, out_mask_next;
    logic               out_done_reg, out_done_next;
    logic [COUNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [SHARE_W-1:0] out_share_reg, out_share_next;
    logic               slot_free;
    logic               load_out;
    logic               ge;

    assign slot_free          = !out_valid_reg || out_ready;
    assign ge                 = rem_reg >= div_reg;
    assign out_valid          = out_valid_reg;
    assign mask_bit           = out_mask_reg;
    assign frame_done         = out_done_reg;
    assign changed_pixels     = out_cnt_reg;
    assign changed_hundredths = out_share_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        quot_next      = quot_reg;
        cnt_hold_next  = cnt_hold_reg;
        mask_hold_next = mask_hold_reg;
        out_mask_next  = out_mask_reg;
        out_done_next  = out_done_reg;
        out_cnt_next   = out_cnt_reg;
        out_share_next = out_share_reg;
        q_pop          = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.last)
                    begin
                        q_pop          = 1'b1;
                        rem_next       = DIV_W'(q_head.changed) * DIV_W'(SHARE_SCALE);
                        div_next       = {q_head.total, {(SHARE_W-1){1'b0}}};
                        quot_next      = '0;
                        step_next      = STEP_W'(SHARE_W - 1);
                        cnt_hold_next  = q_head.changed;
                        mask_hold_next = q_head.mask;
                        state_next     = BK_DIV;
                    end
                    else if (slot_free)
                    begin
                        q_pop          = 1'b1;
                        load_out       = 1'b1;
                        out_mask_next  = q_head.mask;
                        out_done_next  = 1'b0;
                        out_cnt_next   = '0;
                        out_share_next = '0;
                    end
                end
            end
            BK_DIV:
            begin
                rem_next  = ge ? rem_reg - div_reg : rem_reg;
                quot_next = {quot_reg[SHARE_W-2:0], ge};
                div_next  = div_reg >> 1;
                if (step_reg == '0)
                begin
                    state_next = BK_FIN;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            BK_FIN:
            begin
                if (slot_free)
                begin
                    load_out       = 1'b1;
                    out_mask_next  = mask_hold_reg;
                    out_done_next  = 1'b1;
                    out_cnt_next   = cnt_hold_reg;
                    out_share_next = quot_reg;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        quot_reg      <= quot_next;
        cnt_hold_reg  <= cnt_hold_next;
        mask_hold_reg <= mask_hold_next;
        out_mask_reg  <= out_mask_next;
        out_done_reg  <= out_done_next;
        out_cnt_reg   <= out_cnt_next;
        out_share_reg <= out_share_next;
    end

endmodule

`default_nettype wire

FILE: rtl/frame_change_percentage.sv
// ----------------------------------------------------------------------------
// frame_change_percentage
// Frame-difference motion detection on co-located BGR pixel pairs.
// ----------------------------------------------------------------------------
// Takes one previous/current pixel pair per clock while in_ready is high.
// Each pixel gives one result carrying its change mask bit; the result for
// the pixel flagged last_pixel also carries the frame's changed count and
// the changed share in hundredths of a percent, after which the frame
// counters clear. Ordinary pixels are taken one per clock while in_ready
// is high; a result passes the intake register, the queue and the output
// register before it goes valid. A frame-end pixel holds the result stage
// while the bit-serial divider loads, works out 14 quotient bits, one per
// cycle, and unloads. The four-entry queue and the intake register take
// the next five pixels meanwhile, after which the input stalls until the
// queue is popped. The threshold resets to 32; the user is to write it via
// cfg_wr_en/cfg_wr_data only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_change_percentage import fcp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [CHAN_W-1:0]  cfg_wr_data,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic [CHAN_W-1:0]  prev_blue,
    input  wire logic [CHAN_W-1:0]  prev_green,
    input  wire logic [CHAN_W-1:0]  prev_red,
    input  wire logic [CHAN_W-1:0]  curr_blue,
    input  wire logic [CHAN_W-1:0]  curr_green,
    input  wire logic [CHAN_W-1:0]  curr_red,
    input  wire logic               last_pixel,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic               mask_bit,
    output      logic               frame_done,
    output      logic [COUNT_W-1:0] changed_pixels,
    output      logic [SHARE_W-1:0] changed_hundredths
);

    logic      q_full;
    logic      q_empty;
    logic      q_push;
    logic      q_pop;
    fcp_item_t q_item;
    fcp_item_t q_head;

    fcp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .prev_blue   (prev_blue),
        .prev_green  (prev_green),
        .prev_red    (prev_red),
        .curr_blue   (curr_blue),
        .curr_green  (curr_green),
        .curr_red    (curr_red),
        .last_pixel  (last_pixel),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_item)
    );

    fcp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    fcp_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_empty            (q_empty),
        .q_head             (q_head),
        .q_pop              (q_pop),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .mask_bit           (mask_bit),
        .frame_done         (frame_done),
        .changed_pixels     (changed_pixels),
        .changed_hundredths (changed_hundredths)
    );

endmodule

`default_nettype wire

FILE: rtl/fcp_checker.sv
// ----------------------------------------------------------------------------
// fcp_checker
// Port-level checks for frame_change_percentage, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_checker import fcp_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               mask_bit,
    input wire logic               frame_done,
    input wire logic [COUNT_W-1:0] changed_pixels,
    input wire logic [SHARE_W-1:0] changed_hundredths
);

    // result valid, share and frame_done hold while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(changed_hundredths)
            && $stable(frame_done))
        else $error("result dropped or changed while stalled");

    a_mid_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |-> changed_pixels == '0 && changed_hundredths == '0)
        else $error("frame fields nonzero on a mid-frame request");

    a_share_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> changed_hundredths <= SHARE_SCALE)
        else $error("changed share above 100 percent");

    a_zero_share: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done && changed_pixels == '0 |-> changed_hundredths == '0)
        else $error("nonzero share with no changed pixels");

    a_mask_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done && mask_bit |-> changed_pixels != '0)
        else $error("changed last pixel missing from count");

endmodule

bind frame_change_percentage fcp_checker u_fcp_checker (.*);

`default_nettype wire
